### rtl/core/rfm_pkg.sv
// package: types, constants and codes of the reply framer and request matcher
`timescale 1ns / 1ps

package rfm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // input command codes
    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_RXB  = 2'd1;
    localparam logic [1:0] CMD_FAIL = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_OK        = 3'd0;
    localparam logic [2:0] KIND_ERROR     = 3'd1;
    localparam logic [2:0] KIND_UNMATCHED = 3'd2;
    localparam logic [2:0] KIND_WR_FAIL   = 3'd3;
    localparam logic [2:0] KIND_OVERFLOW  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_SYNC_BYTE  = 2'd0;
    localparam logic [1:0] REG_END_BYTE   = 2'd1;
    localparam logic [1:0] REG_ERROR_MASK = 2'd2;
    localparam logic [1:0] REG_TYPE_LIMIT = 2'd3;

    localparam logic [7:0] SYNC_BYTE_RST  = 8'h5B;
    localparam logic [7:0] END_BYTE_RST   = 8'h5D;
    localparam logic [7:0] ERROR_MASK_RST = 8'h80;
    localparam logic [7:0] TYPE_LIMIT_RST = 8'hFF;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] req_type;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0] resp_kind;
        logic [7:0] resp_type;
        logic [7:0] resp_value;
        logic [4:0] dropped;
    } out_word_t;

endpackage

### rtl/core/reply_framer_and_request_matcher_unit.sv
// top level: reply framer, pending request fifo and matcher under one sequencer
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+-----------------------------------
//  in       | input     | in_valid/in_stall  | cmd, req_type, rx_byte
//  out      | output    | out_valid/out_stall| resp_kind, resp_type, resp_value, dropped
//  cfg      | input     | cfg_we             | cfg_index, cfg_data
//
//  enqueue and plain frame bytes are taken in idle; a bad end byte rescans 3 bytes in rescan
//  a write failure passes through the read, compare and emit states
//  a complete frame passes the limit check, then a read and a compare state per pending entry
//  walked through the fifo memory, then emit; a type at or above the limit ends after the check
//  reset is asynchronous, active low, and clears all control state; fifo memory is not cleared
//  in_stall is high while the sequencer is busy; a result waits in the output register
`timescale 1ns / 1ps

module reply_framer_and_request_matcher_unit
    import rfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int DW = (CW > 5) ? CW : 5;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_RESCAN = 6'b000010,
        ST_LIMIT  = 6'b000100,
        ST_READ   = 6'b001000,
        ST_CMP    = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] sync_reg, end_reg, mask_reg, limit_reg;

    logic          phase_reg, phase_next;
    logic [1:0]    held_cnt_reg, held_cnt_next;
    logic [7:0]    held_reg [2];
    logic [QW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] drop_reg, drop_next;
    logic [1:0]    idx_reg, idx_next;
    logic          pop_fail_reg, pop_fail_next;
    logic          out_valid_reg, out_valid_next;

    logic [7:0]    seq_reg [3];
    logic [7:0]    type_reg, value_reg, rd_data_reg;
    logic          err_reg;
    out_word_t     res_reg, res_next;
    out_word_t     out_data_reg;

    logic [7:0]    mem [QUEUE_DEPTH];

    // datapath control from the sequencer
    logic          held_we;
    logic          load_frame;
    logic          load_seq;
    logic          res_we;
    logic          mem_we;

    logic [7:0]    cmp_a, cmp_b;
    logic          cmp_eq, cmp_ge;
    logic [7:0]    scan_b;
    logic          in_acc;
    logic          frame_full;
    logic [CW:0]   tail_sum;
    logic [QW-1:0] tail_addr;
    logic [QW-1:0] head_inc;
    logic [CW-1:0] drop_inc;

    function automatic logic [4:0] sat_drop(input logic [CW-1:0] d);
        logic [DW-1:0] de;
        begin
            de = DW'(d);
            sat_drop = (de > DW'(31)) ? 5'd31 : de[4:0];
        end
    endfunction

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_acc     = in_valid && (state_reg == ST_IDLE);
    assign frame_full = phase_reg && (held_cnt_reg == 2'd2);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    assign tail_sum  = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
    assign tail_addr = (tail_sum >= (CW + 1)'(QUEUE_DEPTH))
                       ? QW'(tail_sum - (CW + 1)'(QUEUE_DEPTH)) : QW'(tail_sum);
    assign head_inc  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign drop_inc  = drop_reg + 1'b1;
    assign scan_b    = (state_reg == ST_RESCAN) ? seq_reg[idx_reg] : in_data.rx_byte;

    // shared compare unit
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                cmp_a = in_data.rx_byte;
                cmp_b = frame_full ? end_reg : sync_reg;
            end
            ST_RESCAN:
            begin
                cmp_a = seq_reg[idx_reg];
                cmp_b = sync_reg;
            end
            ST_LIMIT:
            begin
                cmp_a = type_reg;
                cmp_b = limit_reg;
            end
            ST_CMP:
            begin
                cmp_a = rd_data_reg;
                cmp_b = type_reg;
            end
            default:
            begin
                cmp_a = in_data.rx_byte;
                cmp_b = sync_reg;
            end
        endcase
    end

    assign cmp_eq = (cmp_a == cmp_b);
    assign cmp_ge = (cmp_a >= cmp_b);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        held_cnt_next  = held_cnt_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        idx_next       = idx_reg;
        pop_fail_next  = pop_fail_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        held_we        = 1'b0;
        load_frame     = 1'b0;
        load_seq       = 1'b0;
        res_we         = 1'b0;
        mem_we         = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_data.cmd)
                        CMD_ENQ:
                        begin
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                res_next   = '{KIND_OVERFLOW, in_data.req_type, 8'd0, 5'd0};
                                res_we     = 1'b1;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_RXB:
                        begin
                            if (frame_full)
                            begin
                                phase_next    = 1'b0;
                                held_cnt_next = 2'd0;
                                if (cmp_eq)
                                begin
                                    load_frame = 1'b1;
                                    state_next = ST_LIMIT;
                                end
                                else
                                begin
                                    // bad end byte: rescan the bytes after the old sync
                                    load_seq   = 1'b1;
                                    idx_next   = 2'd0;
                                    state_next = ST_RESCAN;
                                end
                            end
                            else if (!phase_reg)
                            begin
                                if (cmp_eq)
                                begin
                                    phase_next    = 1'b1;
                                    held_cnt_next = 2'd0;
                                end
                            end
                            else
                            begin
                                held_we       = 1'b1;
                                held_cnt_next = held_cnt_reg + 1'b1;
                            end
                        end
                        CMD_FAIL:
                        begin
                            if (count_reg != '0)
                            begin
                                pop_fail_next = 1'b1;
                                state_next    = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RESCAN:
            begin
                if (!phase_reg)
                begin
                    if (cmp_eq)
                    begin
                        phase_next    = 1'b1;
                        held_cnt_next = 2'd0;
                    end
                end
                else if (held_cnt_reg != 2'd2)
                begin
                    held_we       = 1'b1;
                    held_cnt_next = held_cnt_reg + 1'b1;
                end
                if (idx_reg == 2'd2)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_LIMIT:
            begin
                if (cmp_ge)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    drop_next     = '0;
                    pop_fail_next = 1'b0;
                    if (count_reg == '0)
                    begin
                        res_next   = '{KIND_UNMATCHED, type_reg, 8'd0, 5'd0};
                        res_we     = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                head_next  = head_inc;
                count_next = count_reg - 1'b1;
                if (pop_fail_reg)
                begin
                    res_next   = '{KIND_WR_FAIL, rd_data_reg, 8'd0, 5'd0};
                    res_we     = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (cmp_eq)
                begin
                    res_next   = err_reg
                                 ? out_word_t'{KIND_ERROR, type_reg, 8'd0, sat_drop(drop_reg)}
                                 : out_word_t'{KIND_OK, type_reg, value_reg, sat_drop(drop_reg)};
                    res_we     = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    drop_next = drop_inc;
                    if (count_reg == CW'(1))
                    begin
                        res_next   = '{KIND_UNMATCHED, type_reg, 8'd0, sat_drop(drop_inc)};
                        res_we     = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            held_cnt_reg  <= 2'd0;
            head_reg      <= '0;
            count_reg     <= '0;
            drop_reg      <= '0;
            idx_reg       <= 2'd0;
            pop_fail_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sync_reg      <= SYNC_BYTE_RST;
            end_reg       <= END_BYTE_RST;
            mask_reg      <= ERROR_MASK_RST;
            limit_reg     <= TYPE_LIMIT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            held_cnt_reg  <= held_cnt_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            idx_reg       <= idx_next;
            pop_fail_reg  <= pop_fail_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SYNC_BYTE:  sync_reg  <= cfg_data;
                    REG_END_BYTE:   end_reg   <= cfg_data;
                    REG_ERROR_MASK: mask_reg  <= cfg_data;
                    REG_TYPE_LIMIT: limit_reg <= cfg_data;
                    default:        sync_reg  <= sync_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (held_we)
        begin
            held_reg[held_cnt_reg[0]] <= scan_b;
        end
        if (load_frame)
        begin
            type_reg  <= held_reg[0] & ~mask_reg;
            err_reg   <= |(held_reg[0] & mask_reg);
            value_reg <= held_reg[1];
        end
        if (load_seq)
        begin
            seq_reg[0] <= held_reg[0];
            seq_reg[1] <= held_reg[1];
            seq_reg[2] <= in_data.rx_byte;
        end
        if (res_we)
        begin
            res_reg <= res_next;
        end
        if ((state_reg == ST_EMIT) && (!out_valid_reg || !out_stall))
        begin
            out_data_reg <= res_reg;
        end
    end

    // pending type fifo memory, read port always at the head
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_addr] <= in_data.req_type;
        end
        rd_data_reg <= mem[head_reg];
    end

endmodule

### rtl/core/rfm_checker.sv
// checker: port-level assertions for the reply framer and request matcher, with its bind
`timescale 1ns / 1ps

module rfm_checker
    import rfm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_word_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_data
);

    // a stalled input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled input word changed");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result word changed");

    // a new result only appears while the sequencer is busy
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without sequencer activity");

    // only an ok reply carries a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.resp_kind != KIND_OK) |-> (out_data.resp_value == 8'd0))
        else $error("value on a non-ok result");

    // write failure and overflow never report dropped entries
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((out_data.resp_kind == KIND_WR_FAIL) ||
                      (out_data.resp_kind == KIND_OVERFLOW))
        |-> (out_data.dropped == 5'd0))
        else $error("dropped count on a write failure or overflow");

endmodule

bind reply_framer_and_request_matcher_unit rfm_checker u_rfm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

### tb/sv/tb_top.sv
// testbench top: reply framer and request matcher checked against a cycle-free behavioral predictor
`timescale 1ns / 1ps

module tb_top;
    import rfm_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 60;

    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_RUNS, STALL_HEAVY} stall_mode_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_word_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_word_t  out_data;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    reply_framer_and_request_matcher_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies
    logic [7:0] cf_sync;
    logic [7:0] cf_end;
    logic [7:0] cf_mask;
    logic [7:0] cf_limit;

    // framer and request queue state
    bit          fr_collect;
    int unsigned fr_held;
    logic [7:0]  fr_bytes [2];
    logic [7:0]  rq_types [QUEUE_DEPTH];
    int unsigned rq_head;
    int unsigned rq_count;

    in_word_t    event_q [$];
    out_word_t   due_reports [$];
    logic [7:0]  recent_types [$];
    int unsigned queued_n;
    int unsigned taken_n;
    int unsigned fail_n;

    bit          in_taken;
    int unsigned burst_left;
    int unsigned gap_left;
    stall_mode_t stall_mode;
    int unsigned mode_left;
    int unsigned stall_period;
    int unsigned tick;

    always #10 clk = ~clk;

    function automatic logic [7:0] rq_pop();
        logic [7:0] t;
        t = rq_types[rq_head];
        rq_head = (rq_head + 1) % QUEUE_DEPTH;
        rq_count--;
        return t;
    endfunction

    task automatic framer_scan(input logic [7:0] b);
        if (!fr_collect)
        begin
            if (b == cf_sync)
            begin
                fr_collect = 1'b1;
                fr_held = 0;
            end
        end
        else if (fr_held < 2)
        begin
            fr_bytes[fr_held] = b;
            fr_held++;
        end
    endtask

    task automatic match_frame(input logic [7:0] raw, input logic [7:0] val,
                               output bit hit, output out_word_t r);
        bit          err;
        bit          found;
        logic [7:0]  t;
        int unsigned drop;
        err = (raw & cf_mask) != 8'd0;
        t = raw & ~cf_mask;
        drop = 0;
        found = 1'b0;
        r = '0;
        hit = 1'b0;
        // types at or above the limit leave the queue alone
        if (t < cf_limit)
        begin
            hit = 1'b1;
            while (rq_count > 0 && !found)
            begin
                if (rq_pop() == t)
                    found = 1'b1;
                else
                    drop++;
            end
            r.resp_type = t;
            r.dropped = (drop > 31) ? 5'd31 : 5'(drop);
            if (!found)
                r.resp_kind = KIND_UNMATCHED;
            else if (err)
                r.resp_kind = KIND_ERROR;
            else
            begin
                r.resp_kind = KIND_OK;
                r.resp_value = val;
            end
        end
    endtask

    task automatic step_framer_matcher(input in_word_t w);
        out_word_t   r;
        bit          hit;
        logic [7:0]  b0;
        logic [7:0]  b1;
        int unsigned slot;
        hit = 1'b0;
        r = '0;
        case (w.cmd)
            CMD_ENQ:
            begin
                if (rq_count >= QUEUE_DEPTH)
                begin
                    hit = 1'b1;
                    r.resp_kind = KIND_OVERFLOW;
                    r.resp_type = w.req_type;
                end
                else
                begin
                    slot = (rq_head + rq_count) % QUEUE_DEPTH;
                    rq_types[slot] = w.req_type;
                    rq_count++;
                end
            end
            CMD_RXB:
            begin
                if (!fr_collect || fr_held < 2)
                    framer_scan(w.rx_byte);
                else
                begin
                    b0 = fr_bytes[0];
                    b1 = fr_bytes[1];
                    fr_collect = 1'b0;
                    fr_held = 0;
                    if (w.rx_byte == cf_end)
                        match_frame(b0, b1, hit, r);
                    else
                    begin
                        // rescan from the byte after the old sync
                        framer_scan(b0);
                        framer_scan(b1);
                        framer_scan(w.rx_byte);
                    end
                end
            end
            CMD_FAIL:
            begin
                if (rq_count > 0)
                begin
                    hit = 1'b1;
                    r.resp_kind = KIND_WR_FAIL;
                    r.resp_type = rq_pop();
                end
            end
            default:
            begin
            end
        endcase
        if (hit)
            due_reports = {due_reports, r};
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            fail_n++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // result check and input prediction, both on the rising edge
    always @(posedge clk)
    begin : check_and_predict
        out_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (due_reports.size() == 0)
                begin
                    fail_n++;
                    $display("%0t: result with none expected, expected none actual %0h",
                             $time, out_data);
                end
                else
                begin
                    want = due_reports[0];
                    due_reports.delete(0);
                    check_field("resp_kind", 8'(want.resp_kind), 8'(out_data.resp_kind));
                    check_field("resp_type", want.resp_type, out_data.resp_type);
                    check_field("resp_value", want.resp_value, out_data.resp_value);
                    check_field("dropped", 8'(want.dropped), 8'(out_data.dropped));
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
            begin
                taken_n++;
                step_framer_matcher(in_data);
            end
        end
    end

    // sender: bursts of words with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (event_q.size() > 0)
            begin
                in_data <= event_q[0];
                event_q.delete(0);
                in_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left = 0;
                        9:       gap_left = $urandom_range(20, 60);
                        default: gap_left = $urandom_range(1, 12);
                    endcase
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern, re-chosen when its random run length runs out
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
            stall_period = $urandom_range(2, 9);
        end
        mode_left--;
        tick++;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
            STALL_RUNS:  out_stall <= ((tick % stall_period) >= (stall_period / 2));
            default:     out_stall <= ($urandom_range(0, 4) != 0);
        endcase
    end

    task automatic add_word(input logic [1:0] c, input logic [7:0] t, input logic [7:0] b);
        in_word_t w;
        w.cmd = c;
        w.req_type = t;
        w.rx_byte = b;
        event_q = {event_q, w};
        queued_n++;
    endtask

    task automatic add_enq(input logic [7:0] t);
        add_word(CMD_ENQ, t, $urandom_range(0, 255));
        recent_types = {recent_types, t};
        if (recent_types.size() > 8)
            recent_types.delete(0);
    endtask

    task automatic add_rx(input logic [7:0] b);
        add_word(CMD_RXB, $urandom_range(0, 255), b);
    endtask

    task automatic add_frame(input logic [7:0] t, input logic [7:0] v, input logic [7:0] e);
        add_rx(cf_sync);
        add_rx(t);
        add_rx(v);
        add_rx(e);
    endtask

    function automatic logic [7:0] new_type();
        if (cf_limit != 0 && $urandom_range(0, 3) != 0)
            return $urandom_range(0, cf_limit - 1);
        else
            return $urandom_range(0, 255);
    endfunction

    function automatic logic [7:0] pick_type();
        if (recent_types.size() > 0 && $urandom_range(0, 9) < 7)
            return recent_types[$urandom_range(0, recent_types.size() - 1)];
        else
            return $urandom_range(0, 255);
    endfunction

    task automatic run_random(input int unsigned budget);
        int unsigned stop_at;
        int unsigned sel;
        logic [7:0]  t;
        logic [7:0]  e;
        stop_at = queued_n + budget;
        while (queued_n < stop_at)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                repeat ($urandom_range(1, 4)) add_enq(new_type());
            else if (sel < 65)
            begin
                t = pick_type();
                if ($urandom_range(0, 3) == 0)
                    t = t | (cf_mask & 8'($urandom_range(0, 255)));
                add_frame(t, $urandom_range(0, 255), cf_end);
            end
            else if (sel < 75)
            begin
                e = $urandom_range(0, 255);
                if (e == cf_end)
                    e = ~cf_end;
                add_frame(pick_type(), $urandom_range(0, 255), e);
            end
            else if (sel < 85)
                repeat ($urandom_range(1, 3)) add_rx($urandom_range(0, 255));
            else if (sel < 94)
                add_word(CMD_FAIL, $urandom_range(0, 255), $urandom_range(0, 255));
            else if (sel < 97)
                add_word(CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 255));
            else
                repeat (QUEUE_DEPTH + 2) add_enq(new_type());
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_SYNC_BYTE:  cf_sync = val;
            REG_END_BYTE:   cf_end = val;
            REG_ERROR_MASK: cf_mask = val;
            default:        cf_limit = val;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [7:0] s, input logic [7:0] e,
                            input logic [7:0] m, input logic [7:0] l);
        cfg_write(REG_SYNC_BYTE, s);
        cfg_write(REG_END_BYTE, e);
        cfg_write(REG_ERROR_MASK, m);
        cfg_write(REG_TYPE_LIMIT, l);
    endtask

    task automatic wait_drained();
        while (taken_n != queued_n || due_reports.size() != 0)
            @(posedge clk);
        // a last word without a result may still be in the walk
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SYNC_BYTE;
        cfg_data = '0;
        cf_sync = SYNC_BYTE_RST;
        cf_end = END_BYTE_RST;
        cf_mask = ERROR_MASK_RST;
        cf_limit = TYPE_LIMIT_RST;
        fr_collect = 1'b0;
        fr_held = 0;
        rq_head = 0;
        rq_count = 0;
        queued_n = 0;
        taken_n = 0;
        fail_n = 0;
        in_taken = 1'b0;
        burst_left = 1;
        gap_left = 0;
        mode_left = 0;
        tick = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: empty queue cases, match after drops, error reply, bad end
        add_word(CMD_FAIL, 8'h00, 8'h00);
        add_word(CMD_NONE, 8'hFF, 8'hFF);
        add_frame(8'h01, 8'hAA, cf_end);
        add_enq(8'h00);
        add_enq(8'hFF);
        add_enq(8'h22);
        add_frame(8'h22, 8'hFF, cf_end);
        add_enq(8'h33);
        add_frame(8'hB3, 8'h10, cf_end);
        add_enq(8'h44);
        add_word(CMD_FAIL, 8'h00, 8'h00);
        // second sync inside a broken frame starts the next one
        add_rx(8'h5B);
        add_rx(8'h5B);
        add_rx(8'h7E);
        add_rx(8'h00);
        add_rx(8'h5D);
        run_random(280);
        wait_drained();

        set_regs(8'h00, 8'hFF, 8'h00, 8'h10);
        add_frame(8'h10, 8'h01, cf_end);
        add_enq(8'h0F);
        add_frame(8'h0F, 8'h5A, cf_end);
        run_random(240);
        wait_drained();

        set_regs(8'hFF, 8'h00, 8'hFF, 8'hFF);
        run_random(200);
        wait_drained();

        // every reply ignored
        set_regs(SYNC_BYTE_RST, END_BYTE_RST, ERROR_MASK_RST, 8'h00);
        run_random(60);
        wait_drained();

        repeat (3)
        begin
            set_regs($urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(16, 255));
            run_random(200);
            wait_drained();
        end

        if (fail_n == 0 && due_reports.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
